FILE: rtl/core/pcvas_pkg.sv
`timescale 1ns / 1ps

package pcvas_pkg;

  // Coordinate format: two's complement, 1/1024 m steps.
  localparam int COORD_WIDTH = 24;
  // Wide coordinates are scaled down so that each difference fits 25 bits.
  localparam int RED_SHIFT   = (COORD_WIDTH > 24) ? (COORD_WIDTH - 24) : 0;
  localparam int DIFF_W      = COORD_WIDTH + 1 - RED_SHIFT;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int FRAC_SHIFT  = 12;

  // Square-root pipeline, used by every instance: 62-bit radicand, 31-bit root.
  localparam int SQ_IN_W  = 62;
  localparam int SQ_OUT_W = 31;

  localparam int DEN_W = 2 * SQ_OUT_W;
  localparam int REM_W = DEN_W + 2;
  localparam int Q_W   = 17;
  localparam logic [Q_W-1:0] Q_ONE = 17'd65536;
  localparam int SQ_W  = 2 * Q_W;

  localparam int CX_W = 34;
  localparam int Z_W  = 27;
  localparam int CORDIC_STEPS = 24;
  localparam logic signed [Z_W-1:0] ANG_ONE_PI  = 27'sd16777216;
  localparam logic signed [Z_W-1:0] ANG_HALF_PI = 27'sd8388608;

  // Pipeline depth from input register to output register.
  localparam int LAT = 112;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_POSE_X = 3'd0,
    CFG_SRC_POSE_Y = 3'd1,
    CFG_SRC_POSE_Z = 3'd2,
    CFG_TGT_POSE_X = 3'd3,
    CFG_TGT_POSE_Y = 3'd4,
    CFG_TGT_POSE_Z = 3'd5
  } cfg_reg_t;

  // atan(2^-i) in units of pi / 2^24.
  function automatic logic signed [Z_W-1:0] atan_step(input int i);
    logic signed [Z_W-1:0] a;
    a = '0;
    unique case (i)
      0:  a = 27'sd4194304;
      1:  a = 27'sd2476042;
      2:  a = 27'sd1308273;
      3:  a = 27'sd664100;
      4:  a = 27'sd333339;
      5:  a = 27'sd166832;
      6:  a = 27'sd83436;
      7:  a = 27'sd41721;
      8:  a = 27'sd20861;
      9:  a = 27'sd10430;
      10: a = 27'sd5215;
      11: a = 27'sd2608;
      12: a = 27'sd1304;
      13: a = 27'sd652;
      14: a = 27'sd326;
      15: a = 27'sd163;
      16: a = 27'sd81;
      17: a = 27'sd41;
      18: a = 27'sd20;
      19: a = 27'sd10;
      20: a = 27'sd5;
      21: a = 27'sd3;
      22: a = 27'sd1;
      23: a = 27'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/pair_cross_view_angle_score.sv
`timescale 1ns / 1ps

// Cross-view angle score for matched point pairs.
// Input channel: one transaction carries a source point and its matched target
// point (in_valid / in_stall). Result channel: one transaction per input with
// the score 1 - angle/pi in unsigned Q16 and a degenerate flag
// (out_valid / out_stall). The user must write the two sensor poses through
// the cfg port only while the block is idle; the block does not enforce this.
// A write to an index past the pose list is dropped. A pair enters every
// cycle unless in_stall is high. The path holds two 31-stage square-root
// pipelines, a 17-stage divider and a 24-stage CORDIC chain in series.
// The whole pipeline advances together. While the output register holds a
// transaction that the receiver stalls, in_stall is high and every stage holds;
// otherwise bubbles move on and a new pair is taken each cycle.
// Reset clears all valid bits and the pose registers to zero.
module pair_cross_view_angle_score (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [pcvas_pkg::COORD_WIDTH-1:0] in_src_x,
  input  logic signed [pcvas_pkg::COORD_WIDTH-1:0] in_src_y,
  input  logic signed [pcvas_pkg::COORD_WIDTH-1:0] in_src_z,
  input  logic signed [pcvas_pkg::COORD_WIDTH-1:0] in_tgt_x,
  input  logic signed [pcvas_pkg::COORD_WIDTH-1:0] in_tgt_y,
  input  logic signed [pcvas_pkg::COORD_WIDTH-1:0] in_tgt_z,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [pcvas_pkg::Q_W-1:0]               out_cross_score,
  output logic                                    out_degenerate,
  input  logic                                    cfg_we,
  input  logic [pcvas_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pcvas_pkg::COORD_WIDTH-1:0]       cfg_data
);

  localparam int CW = pcvas_pkg::COORD_WIDTH;
  localparam int DW = pcvas_pkg::DIFF_W;
  localparam int PW = pcvas_pkg::PROD_W;
  localparam int SQO = pcvas_pkg::SQ_OUT_W;
  localparam int LATN = pcvas_pkg::LAT;

  // Configuration.
  logic signed [CW-1:0] src_pose_x_r, src_pose_y_r, src_pose_z_r;
  logic signed [CW-1:0] tgt_pose_x_r, tgt_pose_y_r, tgt_pose_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_pose_x_r <= '0;
      src_pose_y_r <= '0;
      src_pose_z_r <= '0;
      tgt_pose_x_r <= '0;
      tgt_pose_y_r <= '0;
      tgt_pose_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcvas_pkg::CFG_SRC_POSE_X: src_pose_x_r <= cfg_data;
        pcvas_pkg::CFG_SRC_POSE_Y: src_pose_y_r <= cfg_data;
        pcvas_pkg::CFG_SRC_POSE_Z: src_pose_z_r <= cfg_data;
        pcvas_pkg::CFG_TGT_POSE_X: tgt_pose_x_r <= cfg_data;
        pcvas_pkg::CFG_TGT_POSE_Y: tgt_pose_y_r <= cfg_data;
        pcvas_pkg::CFG_TGT_POSE_Z: tgt_pose_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control: one enable for all stages.
  logic            en;
  logic [LATN-1:0] vld_r;
  logic [LATN-1:0] vld_nxt;

  assign en       = !(vld_r[LATN-1] && out_stall);
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[LATN-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: sight vectors.
  function automatic logic signed [DW-1:0] sight(input logic signed [CW-1:0] p,
                                                 input logic signed [CW-1:0] q);
    logic signed [CW:0] d;
    logic signed [CW:0] s;
    d = {p[CW-1], p} - {q[CW-1], q};
    s = d >>> pcvas_pkg::RED_SHIFT;
    return s[DW-1:0];
  endfunction

  logic signed [DW-1:0] u0_r, u1_r, u2_r, v0_r, v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      u0_r <= sight(in_src_x, tgt_pose_x_r);
      u1_r <= sight(in_src_y, tgt_pose_y_r);
      u2_r <= sight(in_src_z, tgt_pose_z_r);
      v0_r <= sight(in_tgt_x, src_pose_x_r);
      v1_r <= sight(in_tgt_y, src_pose_y_r);
      v2_r <= sight(in_tgt_z, src_pose_z_r);
    end
  end

  // Stage 2: products.
  logic signed [PW-1:0] uu0_r, uu1_r, uu2_r, vv0_r, vv1_r, vv2_r, dp0_r, dp1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      uu0_r <= u0_r * u0_r;
      uu1_r <= u1_r * u1_r;
      uu2_r <= u2_r * u2_r;
      vv0_r <= v0_r * v0_r;
      vv1_r <= v1_r * v1_r;
      vv2_r <= v2_r * v2_r;
      dp0_r <= u0_r * v0_r;
      dp1_r <= u1_r * v1_r;
    end
  end

  // Stage 3: squared lengths and horizontal dot product.
  logic [PW-1:0]                 nu_nxt, nv_nxt;
  logic [pcvas_pkg::SQ_IN_W-1:0] rad_u_r, rad_v_r;
  logic signed [PW:0]            dot_r;
  logic                          degen_r;

  assign nu_nxt = uu0_r + uu1_r + uu2_r;
  assign nv_nxt = vv0_r + vv1_r + vv2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rad_u_r <= pcvas_pkg::SQ_IN_W'({nu_nxt, 12'b0});
      rad_v_r <= pcvas_pkg::SQ_IN_W'({nv_nxt, 12'b0});
      dot_r   <= {dp0_r[PW-1], dp0_r} + {dp1_r[PW-1], dp1_r};
      degen_r <= (nu_nxt == '0) || (nv_nxt == '0);
    end
  end

  // Lengths, with the dot magnitude and flags carried alongside.
  logic [SQO-1:0] su, sv;

  pcvas_isqrt u_sqrt_u (.clk(clk), .en(en), .radicand(rad_u_r), .root(su));
  pcvas_isqrt u_sqrt_v (.clk(clk), .en(en), .radicand(rad_v_r), .root(sv));

  logic [PW:0]   dot_neg;
  logic [PW-1:0] mag_r   [SQO];
  logic          neg1_r  [SQO];
  logic          dgn1_r  [SQO];

  assign dot_neg = -dot_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[0]  <= dot_r[PW] ? dot_neg[PW-1:0] : dot_r[PW-1:0];
      neg1_r[0] <= dot_r[PW];
      dgn1_r[0] <= degen_r;
      for (int k = 1; k < SQO; k++) begin
        mag_r[k]  <= mag_r[k-1];
        neg1_r[k] <= neg1_r[k-1];
        dgn1_r[k] <= dgn1_r[k-1];
      end
    end
  end

  // Denominator and numerator.
  logic [pcvas_pkg::DEN_W-1:0] den_r;
  logic [pcvas_pkg::REM_W-1:0] num_r;
  logic                        neg2_r, dgn2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= su * sv;
      num_r  <= pcvas_pkg::REM_W'({mag_r[SQO-1], 12'b0});
      neg2_r <= neg1_r[SQO-1];
      dgn2_r <= dgn1_r[SQO-1];
    end
  end

  // Restoring divider: first stage finds saturation and the integer bit,
  // then one fraction bit per stage.
  localparam int DV_N = pcvas_pkg::Q_W;

  logic [pcvas_pkg::REM_W-1:0] dv_rem_r [DV_N];
  logic [pcvas_pkg::DEN_W-1:0] dv_den_r [DV_N];
  logic [pcvas_pkg::Q_W-1:0]   dv_q_r   [DV_N];
  logic                        dv_sat_r [DV_N];
  logic                        dv_neg_r [DV_N];
  logic                        dv_dgn_r [DV_N];

  logic [pcvas_pkg::REM_W-1:0] den_ext;
  logic                        ge0;

  assign den_ext = pcvas_pkg::REM_W'(den_r);
  assign ge0     = num_r >= den_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      dv_sat_r[0] <= num_r >= {den_ext[pcvas_pkg::REM_W-2:0], 1'b0};
      dv_rem_r[0] <= ge0 ? (num_r - den_ext) : num_r;
      dv_q_r[0]   <= {ge0, 16'b0};
      dv_den_r[0] <= den_r;
      dv_neg_r[0] <= neg2_r;
      dv_dgn_r[0] <= dgn2_r;
    end
  end

  for (genvar j = 1; j < DV_N; j++) begin : g_div
    logic [pcvas_pkg::REM_W-1:0] rem2;
    logic [pcvas_pkg::REM_W-1:0] dext;
    logic                        ge;

    assign rem2 = {dv_rem_r[j-1][pcvas_pkg::REM_W-2:0], 1'b0};
    assign dext = pcvas_pkg::REM_W'(dv_den_r[j-1]);
    assign ge   = rem2 >= dext;

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[j] <= ge ? (rem2 - dext) : rem2;
        dv_q_r[j]   <= dv_q_r[j-1] | (pcvas_pkg::Q_W'(ge) << (DV_N - 1 - j));
        dv_den_r[j] <= dv_den_r[j-1];
        dv_sat_r[j] <= dv_sat_r[j-1];
        dv_neg_r[j] <= dv_neg_r[j-1];
        dv_dgn_r[j] <= dv_dgn_r[j-1];
      end
    end
  end

  // Cosine magnitude, its square, then the sine radicand 2^32 - c^2.
  logic [pcvas_pkg::Q_W-1:0]     qf_r, qf2_r, qf3_r;
  logic                          neg3_r, neg4_r, neg5_r;
  logic                          dgn3_r, dgn4_r, dgn5_r;
  logic [pcvas_pkg::SQ_W-1:0]    csq_r;
  logic [pcvas_pkg::SQ_IN_W-1:0] rad_s_r;
  logic [pcvas_pkg::SQ_W-1:0]    two32;

  assign two32 = pcvas_pkg::SQ_W'(1) << 32;

  always_ff @(posedge clk) begin
    if (en) begin
      qf_r    <= (dv_sat_r[DV_N-1] || dv_q_r[DV_N-1] > pcvas_pkg::Q_ONE) ?
                 pcvas_pkg::Q_ONE : dv_q_r[DV_N-1];
      neg3_r  <= dv_neg_r[DV_N-1];
      dgn3_r  <= dv_dgn_r[DV_N-1];
      csq_r   <= qf_r * qf_r;
      qf2_r   <= qf_r;
      neg4_r  <= neg3_r;
      dgn4_r  <= dgn3_r;
      rad_s_r <= pcvas_pkg::SQ_IN_W'(two32 - csq_r);
      qf3_r   <= qf2_r;
      neg5_r  <= neg4_r;
      dgn5_r  <= dgn4_r;
    end
  end

  logic [SQO-1:0] s_root;

  pcvas_isqrt u_sqrt_s (.clk(clk), .en(en), .radicand(rad_s_r), .root(s_root));

  logic [pcvas_pkg::Q_W-1:0] qd_r   [SQO];
  logic                      neg6_r [SQO];
  logic                      dgn6_r [SQO];

  always_ff @(posedge clk) begin
    if (en) begin
      qd_r[0]   <= qf3_r;
      neg6_r[0] <= neg5_r;
      dgn6_r[0] <= dgn5_r;
      for (int k = 1; k < SQO; k++) begin
        qd_r[k]   <= qd_r[k-1];
        neg6_r[k] <= neg6_r[k-1];
        dgn6_r[k] <= dgn6_r[k-1];
      end
    end
  end

  // CORDIC vectoring. A negative cosine starts pre-rotated by 90 degrees.
  localparam int NC = pcvas_pkg::CORDIC_STEPS;

  logic signed [pcvas_pkg::CX_W-1:0] cx_r [NC+1];
  logic signed [pcvas_pkg::CX_W-1:0] cy_r [NC+1];
  logic signed [pcvas_pkg::Z_W-1:0]  cz_r [NC+1];
  logic                              cd_r [NC+1];

  logic signed [pcvas_pkg::CX_W-1:0] q4096, s4096;
  logic                              cneg;

  assign q4096 = signed'(pcvas_pkg::CX_W'({qd_r[SQO-1], 12'b0}));
  assign s4096 = signed'(pcvas_pkg::CX_W'({s_root[16:0], 12'b0}));
  assign cneg  = neg6_r[SQO-1] && (qd_r[SQO-1] != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= cneg ? s4096 : q4096;
      cy_r[0] <= cneg ? q4096 : s4096;
      cz_r[0] <= cneg ? pcvas_pkg::ANG_HALF_PI : '0;
      cd_r[0] <= dgn6_r[SQO-1];
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    localparam logic signed [pcvas_pkg::Z_W-1:0] ATAN = pcvas_pkg::atan_step(i);
    logic signed [pcvas_pkg::CX_W-1:0] dx, dy;

    assign dx = cy_r[i] >>> i;
    assign dy = cx_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy_r[i][pcvas_pkg::CX_W-1]) begin
          cx_r[i+1] <= cx_r[i] + dx;
          cy_r[i+1] <= cy_r[i] - dy;
          cz_r[i+1] <= cz_r[i] + ATAN;
        end else begin
          cx_r[i+1] <= cx_r[i] - dx;
          cy_r[i+1] <= cy_r[i] + dy;
          cz_r[i+1] <= cz_r[i] - ATAN;
        end
        cd_r[i+1] <= cd_r[i];
      end
    end
  end

  // Output register.
  logic signed [pcvas_pkg::Z_W-1:0] zc;
  logic signed [pcvas_pkg::Z_W-1:0] sc_full;
  logic [pcvas_pkg::Q_W-1:0]        score_r;
  logic                             degen_out_r;

  always_comb begin
    if (cz_r[NC] < 0) begin
      zc = '0;
    end else if (cz_r[NC] > pcvas_pkg::ANG_ONE_PI) begin
      zc = pcvas_pkg::ANG_ONE_PI;
    end else begin
      zc = cz_r[NC];
    end
    sc_full = pcvas_pkg::ANG_ONE_PI - zc + 27'sd128;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      score_r     <= cd_r[NC] ? '0 : sc_full[24:8];
      degen_out_r <= cd_r[NC];
    end
  end

  assign out_valid       = vld_r[LATN-1];
  assign out_cross_score = score_r;
  assign out_degenerate  = degen_out_r;

  // Checks.
  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted transaction did not enter the pipeline");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(vld_r))
    else $error("pipeline moved while output was stalled");

  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_cross_score == '0)
    else $error("degenerate result with nonzero score");

  a_score_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cross_score <= pcvas_pkg::Q_ONE)
    else $error("score above one");

endmodule

FILE: rtl/core/pcvas_isqrt.sv
`timescale 1ns / 1ps

// Floor square root, one result bit per register stage.
module pcvas_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pcvas_pkg::SQ_IN_W-1:0] radicand,
  output logic [pcvas_pkg::SQ_OUT_W-1:0] root
);

  logic [pcvas_pkg::SQ_IN_W-1:0] n_r [pcvas_pkg::SQ_OUT_W];
  logic [pcvas_pkg::SQ_IN_W-1:0] r_r [pcvas_pkg::SQ_OUT_W];

  for (genvar k = 0; k < pcvas_pkg::SQ_OUT_W; k++) begin : g_stage
    localparam logic [pcvas_pkg::SQ_IN_W-1:0] BIT =
      pcvas_pkg::SQ_IN_W'(1) << (2 * (pcvas_pkg::SQ_OUT_W - 1 - k));
    logic [pcvas_pkg::SQ_IN_W-1:0] n_in;
    logic [pcvas_pkg::SQ_IN_W-1:0] r_in;
    logic [pcvas_pkg::SQ_IN_W:0]   trial;
    logic [pcvas_pkg::SQ_IN_W-1:0] n_nxt;
    logic [pcvas_pkg::SQ_IN_W-1:0] r_nxt;

    if (k == 0) begin : g_first
      assign n_in = radicand;
      assign r_in = '0;
    end else begin : g_rest
      assign n_in = n_r[k-1];
      assign r_in = r_r[k-1];
    end

    always_comb begin
      trial = {1'b0, r_in} + {1'b0, BIT};
      if ({1'b0, n_in} >= trial) begin
        n_nxt = n_in - trial[pcvas_pkg::SQ_IN_W-1:0];
        r_nxt = (r_in >> 1) + BIT;
      end else begin
        n_nxt = n_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= n_nxt;
        r_r[k] <= r_nxt;
      end
    end
  end

  assign root = r_r[pcvas_pkg::SQ_OUT_W-1][pcvas_pkg::SQ_OUT_W-1:0];

endmodule
